// File: rtl/sliding_window_sparkline_scaler_macros.svh
// Assertion macros, clocked on i_clk and disabled while i_rst_n is low.
`ifndef SLIDING_WINDOW_SPARKLINE_SCALER_MACROS_SVH
`define SLIDING_WINDOW_SPARKLINE_SCALER_MACROS_SVH

`ifndef SYNTHESIS
`define SWSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SWSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWSS_ASSERT(label, prop, msg)
`define SWSS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/swss_pkg.sv
`default_nettype none
package swss_pkg;

    localparam int HISTORY_DEPTH_DEF = 10;

    localparam int SAMPLE_W  = 8;
    localparam int COORD_W   = 8;
    localparam int IDX_W     = 5;
    localparam int CFG_IDX_W = 8;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 8'd1;

    localparam logic [COORD_W-1:0] CANVAS_WIDTH_RST  = 8'd128;
    localparam logic [COORD_W-1:0] CANVAS_HEIGHT_RST = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPACE,
        ST_READ,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_EMIT
    } t_state;

    // quotient must fit in 8 bits: dividend[15:8] < divisor
    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [SAMPLE_W-1:0] divisor;
    } t_div_req;

endpackage
`default_nettype wire

// File: rtl/sliding_window_sparkline_scaler.sv
// Sliding-window sparkline scaler: one sample in, HISTORY_DEPTH plot points out.
// A new sample is taken only when idle, once the previous sample's last point has
// been issued. Each point needs one divide on the 8-step serial divider, and the
// scan of the history reads one entry per cycle.
// Reset (synchronous, active low) empties the history, so every sample reads
// as zero, and loads width 128 and height 32.
`default_nettype none
`include "sliding_window_sparkline_scaler_macros.svh"
module sliding_window_sparkline_scaler #(
    parameter int HISTORY_DEPTH = swss_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [swss_pkg::SAMPLE_W-1:0]    i_wpm_sample,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [swss_pkg::IDX_W-1:0]       o_point_index,
    output logic      [swss_pkg::COORD_W-1:0]     o_point_x,
    output logic      [swss_pkg::COORD_W-1:0]     o_point_y,
    output logic                                  o_last_point,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [swss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [swss_pkg::COORD_W-1:0]     i_cfg_data
);

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int AW1 = AW + 1;
    localparam logic [AW:0]   DEPTH_W = AW1'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(HISTORY_DEPTH - 1);
    localparam int SPACE_SHIFT = 16;
    localparam int RECIP_W     = SPACE_SHIFT + 1;
    localparam int SPACE_PW    = SPACE_SHIFT + swss_pkg::COORD_W;
    // ceil(2^16 / (HISTORY_DEPTH - 1)): exact quotient for any 8-bit dividend
    localparam logic [RECIP_W-1:0] SPACE_RECIP =
        RECIP_W'((2 ** SPACE_SHIFT + HISTORY_DEPTH - 2) / (HISTORY_DEPTH - 1));

    swss_pkg::t_state r_state;
    swss_pkg::t_state n_state;

    logic [AW-1:0]                  r_ptr;
    logic [AW-1:0]                  r_cnt;
    logic [HISTORY_DEPTH-1:0]       r_valid;
    logic                           r_issue_done;
    logic                           r_rd_pend;
    logic                           r_rd_last;
    logic                           r_rd_vbit;
    logic [swss_pkg::COORD_W-1:0]   r_width;
    logic [swss_pkg::COORD_W-1:0]   r_height;
    logic [swss_pkg::SAMPLE_W-1:0]  r_lo;
    logic [swss_pkg::SAMPLE_W-1:0]  r_hi;
    logic [swss_pkg::COORD_W-1:0]   r_spacing;
    logic [swss_pkg::COORD_W-1:0]   r_x;
    logic [swss_pkg::PROD_W-1:0]    r_prod;
    logic [swss_pkg::SAMPLE_W-1:0]  r_drop;
    logic                           r_out_valid;
    logic [swss_pkg::IDX_W-1:0]     r_out_idx;
    logic [swss_pkg::COORD_W-1:0]   r_out_x;
    logic [swss_pkg::COORD_W-1:0]   r_out_y;
    logic                           r_out_last;

    logic [AW:0]                    w_sum;
    logic [AW-1:0]                  w_rd_addr;
    logic [AW-1:0]                  w_ptr_next;
    logic [swss_pkg::SAMPLE_W-1:0]  w_rdata;
    logic [swss_pkg::SAMPLE_W-1:0]  w_sample;
    logic [swss_pkg::SAMPLE_W-1:0]  w_range;
    logic [swss_pkg::COORD_W-1:0]   w_wsub;
    logic [SPACE_PW-1:0]            w_space_prod;
    logic [swss_pkg::COORD_W-1:0]   w_spacing;
    logic [swss_pkg::COORD_W-1:0]   w_base;
    logic [swss_pkg::COORD_W-1:0]   w_span;
    logic [swss_pkg::COORD_W-1:0]   w_y;
    logic                           w_in_acc;
    logic                           w_out_free;
    logic                           w_emit;
    logic                           w_div_done;
    logic [swss_pkg::SAMPLE_W-1:0]  w_quo;
    swss_pkg::t_div_req             w_div_req;

    assign o_in_ready  = (r_state == swss_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_emit      = (r_state == swss_pkg::ST_EMIT) && w_out_free;

    // oldest entry sits at r_ptr; walk forward with wrap
    assign w_sum      = {1'b0, r_ptr} + {1'b0, r_cnt};
    assign w_rd_addr  = (w_sum >= DEPTH_W) ? AW'(w_sum - DEPTH_W) : AW'(w_sum);
    assign w_ptr_next = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;

    assign w_sample = r_rd_vbit ? w_rdata : '0;
    assign w_range  = (r_hi == r_lo) ? swss_pkg::SAMPLE_W'(1) : r_hi - r_lo;
    assign w_wsub   = (r_width >= 8'd4) ? r_width - 8'd4 : '0;
    assign w_base   = (r_height >= 8'd4) ? r_height - 8'd4 : '0;
    assign w_span   = (r_height >= 8'd8) ? r_height - 8'd8 : '0;
    assign w_y      = (r_drop <= w_base) ? w_base - r_drop : '0;

    // spacing by reciprocal multiplication, the divisor being fixed
    assign w_space_prod = SPACE_PW'(w_wsub) * SPACE_PW'(SPACE_RECIP);
    assign w_spacing    = w_space_prod[SPACE_PW-1:SPACE_SHIFT];

    swss_ram #(
        .WIDTH (swss_pkg::SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_ptr),
        .i_wdata (i_wpm_sample),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    swss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    always_comb begin
        n_state   = r_state;
        w_div_req = '0;
        case (r_state)
            swss_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = swss_pkg::ST_SCAN;
                end
            end
            swss_pkg::ST_SCAN: begin
                if (r_rd_pend && r_rd_last) begin
                    n_state = swss_pkg::ST_SPACE;
                end
            end
            swss_pkg::ST_SPACE: begin
                n_state = swss_pkg::ST_READ;
            end
            swss_pkg::ST_READ: begin
                n_state = swss_pkg::ST_MUL;
            end
            swss_pkg::ST_MUL: begin
                n_state = swss_pkg::ST_DIVGO;
            end
            swss_pkg::ST_DIVGO: begin
                n_state            = swss_pkg::ST_DIV;
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_prod;
                w_div_req.divisor  = w_range;
            end
            swss_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = swss_pkg::ST_EMIT;
                end
            end
            swss_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = (r_cnt == LAST) ? swss_pkg::ST_IDLE : swss_pkg::ST_READ;
                end
            end
            default: begin
                n_state = swss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= swss_pkg::ST_IDLE;
            r_ptr        <= '0;
            r_cnt        <= '0;
            r_valid      <= '0;
            r_issue_done <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_width      <= swss_pkg::CANVAS_WIDTH_RST;
            r_height     <= swss_pkg::CANVAS_HEIGHT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == swss_pkg::ST_SCAN) && !r_issue_done;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    swss_pkg::REG_CANVAS_WIDTH:  r_width  <= i_cfg_data;
                    swss_pkg::REG_CANVAS_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end

            // overwrite the oldest slot; the next one becomes the oldest
            if (w_in_acc) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr          <= w_ptr_next;
                r_cnt          <= '0;
                r_issue_done   <= 1'b0;
            end

            if (r_state == swss_pkg::ST_SCAN && !r_issue_done) begin
                if (r_cnt == LAST) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end

            if (r_state == swss_pkg::ST_SPACE) begin
                r_cnt <= '0;
            end

            if (w_emit) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vbit <= r_valid[w_rd_addr];
        r_rd_last <= (r_cnt == LAST);

        if (w_in_acc) begin
            r_lo <= '1;
            r_hi <= '0;
        end else if (r_state == swss_pkg::ST_SCAN && r_rd_pend) begin
            if (w_sample < r_lo) begin
                r_lo <= w_sample;
            end
            if (w_sample > r_hi) begin
                r_hi <= w_sample;
            end
        end

        if (r_state == swss_pkg::ST_SPACE) begin
            r_spacing <= w_spacing;
            r_x       <= swss_pkg::COORD_W'(2);
        end

        if (r_state == swss_pkg::ST_MUL) begin
            r_prod <= swss_pkg::PROD_W'(w_sample - r_lo) * swss_pkg::PROD_W'(w_span);
        end

        if (r_state == swss_pkg::ST_DIV && w_div_done) begin
            r_drop <= w_quo;
        end

        // x wraps modulo 256 like the coordinate field
        if (w_emit) begin
            r_out_idx  <= swss_pkg::IDX_W'(r_cnt);
            r_out_x    <= r_x;
            r_out_y    <= w_y;
            r_out_last <= (r_cnt == LAST);
            r_x        <= r_x + r_spacing;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_index = r_out_idx;
    assign o_point_x     = r_out_x;
    assign o_point_y     = r_out_y;
    assign o_last_point  = r_out_last;

    `SWSS_ASSERT_NEXT(a_accept_starts_scan, w_in_acc, r_state == swss_pkg::ST_SCAN, "no scan")
    `SWSS_ASSERT(a_min_below_max, (r_state == swss_pkg::ST_SPACE) |-> (r_lo <= r_hi), "lo > hi")
    `SWSS_ASSERT(a_drop_in_span, (r_state == swss_pkg::ST_EMIT) |-> (r_drop <= w_span), "big drop")

endmodule
`default_nettype wire

// File: rtl/swss_ram.sv
`default_nettype none
module swss_ram #(
    parameter int WIDTH = swss_pkg::SAMPLE_W,
    parameter int DEPTH = swss_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/swss_div.sv
`default_nettype none
module swss_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire swss_pkg::t_div_req              i_req,
    output logic      [swss_pkg::SAMPLE_W-1:0]   o_quotient,
    output logic                                 o_done
);

    logic [swss_pkg::SAMPLE_W-1:0] r_rem;
    logic [swss_pkg::SAMPLE_W-1:0] r_quo;
    logic [swss_pkg::SAMPLE_W-1:0] r_div;
    logic [swss_pkg::STEP_W-1:0]   r_step;
    logic                          r_busy;
    logic                          r_done;
    logic [swss_pkg::SAMPLE_W:0]   w_trial;
    logic                          w_fit;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[swss_pkg::SAMPLE_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_req.start &&
                      (r_step == swss_pkg::STEP_W'(swss_pkg::DIV_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == swss_pkg::STEP_W'(swss_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[swss_pkg::PROD_W-1:swss_pkg::SAMPLE_W];
            r_quo <= i_req.dividend[swss_pkg::SAMPLE_W-1:0];
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? swss_pkg::SAMPLE_W'(w_trial - {1'b0, r_div})
                           : w_trial[swss_pkg::SAMPLE_W-1:0];
            r_quo <= {r_quo[swss_pkg::SAMPLE_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule
`default_nettype wire

// File: tb/sv/sparkline_point_checker.sv
`timescale 1ns / 100ps
module sparkline_point_checker
    import swss_pkg::*;
#(
    parameter int DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [SAMPLE_W-1:0]  i_wpm_sample,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [IDX_W-1:0]     i_point_index,
    input  logic [COORD_W-1:0]   i_point_x,
    input  logic [COORD_W-1:0]   i_point_y,
    input  logic                 i_last_point,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } plot_point_t;

    logic [SAMPLE_W-1:0] history [DEPTH];
    logic [COORD_W-1:0]  canvas_w;
    logic [COORD_W-1:0]  canvas_h;
    plot_point_t         expected_points [$];
    int                  fails = 0;

    // Shift the new sample in at the newest end, then queue one point per entry.
    task automatic plot_history(input logic [SAMPLE_W-1:0] sample);
        int unsigned lo;
        int unsigned hi;
        int unsigned span_v;
        int unsigned spread;
        int unsigned spacing;
        int unsigned base;
        int unsigned drop;
        int          i;
        plot_point_t pt;
        lo = 255;
        hi = 0;
        for (i = 0; i < DEPTH - 1; i++) history[i] = history[i + 1];
        history[DEPTH - 1] = sample;
        for (i = 0; i < DEPTH; i++) begin
            if (history[i] > hi) hi = history[i];
            if (history[i] < lo) lo = history[i];
        end
        spread = (hi == lo) ? 1 : hi - lo;
        // clamp the canvas terms at zero on tiny canvases
        spacing = (canvas_w >= 4) ? (canvas_w - 4) / (DEPTH - 1) : 0;
        base    = (canvas_h >= 4) ? canvas_h - 4 : 0;
        span_v  = (canvas_h >= 8) ? canvas_h - 8 : 0;
        for (i = 0; i < DEPTH; i++) begin
            drop     = ((history[i] - lo) * span_v) / spread;
            pt.index = IDX_W'(i);
            pt.x     = COORD_W'(2 + i * spacing);
            pt.y     = (drop <= base) ? COORD_W'(base - drop) : '0;
            pt.last  = (i == DEPTH - 1);
            expected_points.push_back(pt);
        end
    endtask

    always @(posedge i_clk) begin
        plot_point_t got;
        plot_point_t want;
        if (!i_rst_n) begin
            history  = '{default: '0};
            canvas_w = CANVAS_WIDTH_RST;
            canvas_h = CANVAS_HEIGHT_RST;
            expected_points.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_CANVAS_WIDTH) canvas_w = i_cfg_data;
                else if (i_cfg_index == REG_CANVAS_HEIGHT) canvas_h = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) plot_history(i_wpm_sample);
            if (i_out_valid && i_out_ready) begin
                got = {i_point_index, i_point_x, i_point_y, i_last_point};
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected point idx %0d x %0d y %0d last %0b",
                             $time, got.index, got.x, got.y, got.last);
                    fails++;
                end else begin
                    want = expected_points.pop_front();
                    if (got !== want) begin
                        $display("%0t: point mismatch, expected idx %0d x %0d y %0d last %0b, got idx %0d x %0d y %0d last %0b",
                                 $time, want.index, want.x, want.y, want.last,
                                 got.index, got.x, got.y, got.last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_points.size();
    end
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import swss_pkg::*;

    localparam int DEPTH        = HISTORY_DEPTH_DEF;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int CHUNKS       = 7;
    localparam int CHUNK_ITEMS  = 12;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  wpm_sample;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [IDX_W-1:0]     point_index;
    logic [COORD_W-1:0]   point_x;
    logic [COORD_W-1:0]   point_y;
    logic                 last_point;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    bit hold_taken = 1'b0;
    int hold_left  = 0;
    int stall_cycles = 0;

    sliding_window_sparkline_scaler #(
        .HISTORY_DEPTH(DEPTH)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_wpm_sample (wpm_sample),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_point_index(point_index),
        .o_point_x    (point_x),
        .o_point_y    (point_y),
        .o_last_point (last_point),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    sparkline_point_checker #(
        .DEPTH(DEPTH)
    ) point_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_wpm_sample (wpm_sample),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_point_index(point_index),
        .i_point_x    (point_x),
        .i_point_y    (point_y),
        .i_last_point (last_point),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        wpm_sample <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait until every queued point has been taken.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // junk_idx < 0 means no write to an unused register index.
    task automatic set_canvas(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                              input int junk_idx);
        logic [CFG_IDX_W+COORD_W-1:0] writes [$];
        settle();
        if (junk_idx >= 0)
            writes.push_back({CFG_IDX_W'(junk_idx), COORD_W'($urandom)});
        writes.push_back({REG_CANVAS_WIDTH, w});
        writes.push_back({REG_CANVAS_HEIGHT, h});
        foreach (writes[k]) begin
            cfg_valid              <= 1'b1;
            {cfg_index, cfg_data}  <= writes[k];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] pick_canvas();
        case ($urandom_range(5))
            0:       return COORD_W'($urandom_range(9));
            1:       return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] prev;
        int                  n;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        wpm_sample  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req    = 1'b0;
        tx_idle_pct = 21;
        rx_idle_pct = 62;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset canvas; the first sample leaves a flat all-zero history
        send_sample(8'd0);
        send_sample(8'd255);
        send_sample(8'd128);
        send_sample(8'd1);
        send_sample(8'd254);
        set_canvas(8'd255, 8'd255, 8'hFF);
        send_sample(8'd255);
        send_sample(8'd0);
        send_sample(8'd37);
        // narrow and short canvas: every point collapses to x 2, y 0
        set_canvas(8'd0, 8'd0, REG_CANVAS_HEIGHT + 1);
        send_sample(8'd200);
        send_sample(8'd3);
        set_canvas(8'd3, 8'd7, -1);
        send_sample(8'd9);
        send_sample(8'd250);
        set_canvas(8'd4, 8'd8, -1);
        send_sample(8'd77);
        send_sample(8'd0);
        set_canvas(8'd8, 8'd9, -1);
        send_sample(8'd255);
        send_sample(8'd128);
        set_canvas(8'd5, 8'd4, -1);
        send_sample(8'd66);
        set_canvas(8'd13, 8'd3, -1);
        send_sample(8'd12);

        prev = 8'd12;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < CHUNKS; c++) begin
                set_canvas(pick_canvas(), pick_canvas(),
                           ($urandom_range(3) == 0) ? int'($urandom_range(2, 255)) : -1);
                if (c == 0) begin
                    tx_idle_pct <= (r == 0) ? 21 : (r == 1) ? 62 : 0;
                    rx_idle_pct <= (r == 0) ? 62 : (r == 1) ? 21 : 0;
                    // stall the receiver while the sender keeps pushing
                    hold_req    <= (r == 2);
                end
                n = 0;
                if ($urandom_range(4) == 0) begin
                    // a run long enough to flatten the whole history
                    prev = SAMPLE_W'($urandom);
                    for (n = 0; n < DEPTH + 1; n++) send_sample(prev);
                end
                for (; n < CHUNK_ITEMS; n++) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: prev = SAMPLE_W'($urandom);
                        6, 7:             prev = prev;
                        8:                prev = ($urandom_range(1) != 0) ? '1 : '0;
                        default:          prev = prev ^ SAMPLE_W'(1 << $urandom_range(7));
                    endcase
                    send_sample(prev);
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
